// ----- rtl/ptdw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptdw_pkg - page table dump walker shared definitions
// Entry bit positions, address widths and the result record passed from the
// step logic to the result register.
// ----------------------------------------------------------------------------
package ptdw_pkg;

   localparam int WORD_W      = 64;
   localparam int PA_W        = 63;
   localparam int VA_W        = 48;
   localparam int LEVEL_W     = 2;
   localparam int PAGE_SHIFT  = 12;

   localparam int PRESENT_BIT = 0;
   localparam int WRITE_BIT   = 1;
   localparam int USER_BIT    = 2;
   localparam int HUGE_BIT    = 7;
   localparam int NX_BIT      = 63;

   typedef struct packed {
      logic               is_leaf;
      logic [LEVEL_W-1:0] leaf_level;
      logic [PA_W-1:0]    phys_addr;
      logic [VA_W-1:0]    virt_addr;
      logic               can_write;
      logic               can_execute;
      logic               user_access;
      logic               walk_end;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/ptdw_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ptdw_step - one dump word through the walker
// Decodes a header or entry word against the current walk position and
// produces the next position and, where one is due, the result record.
// ----------------------------------------------------------------------------
module ptdw_step #(
   parameter int  LEVELS            = 4,
   parameter int  ENTRIES_PER_TABLE = 512,
   localparam int IB                = $clog2(ENTRIES_PER_TABLE),
   localparam int LW                = $clog2(LEVELS)
) (
   input  wire logic [ptdw_pkg::WORD_W-1:0] word,
   input  wire logic                        hdr_pending,
   input  wire logic [LW-1:0]               cur_level,
   input  wire logic [LEVELS-1:0][IB-1:0]   level_index,
   output      logic                        hdr_pending_in,
   output      logic [LW-1:0]               current_level_in,
   output      logic [LEVELS-1:0][IB-1:0]   level_index_in,
   output      logic                        has_result,
   output      ptdw_pkg::rsp_type           rsp
);
   import ptdw_pkg::*;

   localparam int FULL_W = LEVELS * IB + PAGE_SHIFT;

   logic [LEVELS-1:0]       last;
   logic                    present;
   logic                    huge;
   logic                    descend;
   logic                    leaf;
   logic                    inc;
   logic                    carry;
   logic                    walk_end;
   logic [FULL_W-1:0]       va_full;
   logic [FULL_W+VA_W-1:0]  va_wide;

   assign present = word[PRESENT_BIT];
   assign huge    = word[HUGE_BIT];
   assign descend = (cur_level != '0) && present && !huge;
   assign leaf    = (cur_level != '0) ? (present && huge) : (|word);

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         last[l] = (level_index[l] == IB'(ENTRIES_PER_TABLE - 1));
      end
   end

   // indices from the leaf level up, each in its own slice of the address
   always_comb begin
      va_full = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (LW'(l) >= cur_level) begin
            va_full[l*IB+PAGE_SHIFT +: IB] = level_index[l];
         end
      end
      va_wide = (FULL_W+VA_W)'(va_full);
   end

   always_comb begin
      level_index_in   = level_index;
      current_level_in = cur_level;
      hdr_pending_in   = hdr_pending;
      has_result       = 1'b0;
      rsp              = '0;
      inc              = 1'b0;
      carry            = 1'b0;
      walk_end         = 1'b0;
      if (hdr_pending) begin
         hdr_pending_in = 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            if (LW'(l) == cur_level) begin
               level_index_in[l] = '0;
            end
         end
      end else if (descend) begin
         current_level_in = cur_level - 1'b1;
         hdr_pending_in   = 1'b1;
      end else begin
         // advance this level, popping through every finished page above it
         for (int l = 0; l < LEVELS; l++) begin
            inc = (LW'(l) == cur_level) || carry;
            if (inc) begin
               level_index_in[l] = last[l] ? '0 : level_index[l] + IB'(1);
               if (!last[l]) begin
                  current_level_in = LW'(l);
               end
            end
            carry = inc && last[l];
         end
         walk_end = carry;
         if (walk_end) begin
            level_index_in   = '0;
            current_level_in = LW'(LEVELS - 1);
            hdr_pending_in   = 1'b1;
         end
         has_result   = leaf || walk_end;
         rsp.walk_end = walk_end;
         if (leaf) begin
            rsp.is_leaf     = 1'b1;
            rsp.leaf_level  = LEVEL_W'(cur_level);
            rsp.phys_addr   = {word[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            rsp.virt_addr   = va_wide[VA_W-1:0];
            rsp.can_write   = word[WRITE_BIT];
            rsp.can_execute = !word[NX_BIT];
            rsp.user_access = word[USER_BIT];
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/page_table_dump_walker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_dump_walker - streaming walker over a serialized page table dump
// Takes a depth-first dump one 64-bit word per beat and reports every mapped
// leaf entry, and flags walk end on the beat that finishes the root page.
// ----------------------------------------------------------------------------
// The block takes one dump word per cycle unless stalled; the result of each
// taken beat passes through the input register and then the result register.
// Header words and descending entries give no result beat. Each word is
// decoded combinationally against the walk position (current level and one
// entry index per level), so a result waiting on a stalled output holds only
// the word behind it; the input stalls only when both registers are full.
// After reset the walker expects the header of a root page, and it rearms
// itself the same way after each root page finishes.
module page_table_dump_walker #(
   parameter int  LEVELS            = 4,
   parameter int  ENTRIES_PER_TABLE = 512,
   localparam int IB                = $clog2(ENTRIES_PER_TABLE),
   localparam int LW                = $clog2(LEVELS)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [63:0] req_word,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_is_leaf,
   output      logic [1:0]  rsp_leaf_level,
   output      logic [62:0] rsp_phys_addr,
   output      logic [47:0] rsp_virt_addr,
   output      logic        rsp_can_write,
   output      logic        rsp_can_execute,
   output      logic        rsp_user_access,
   output      logic        rsp_walk_end
);
   import ptdw_pkg::*;

   logic                      req_valid_ff;
   logic [WORD_W-1:0]         req_word_ff;
   logic                      hdr_pending_ff;
   logic                      hdr_pending_in;
   logic [LW-1:0]             current_level_ff;
   logic [LW-1:0]             current_level_in;
   logic [LEVELS-1:0][IB-1:0] level_index_ff;
   logic [LEVELS-1:0][IB-1:0] level_index_in;
   logic                      step_has_result;
   rsp_type                   step_rsp;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_type                   rsp_ff;
   logic                      out_free;
   logic                      fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_word_ff <= req_word;
      end
   end

   ptdw_step #(
      .LEVELS            (LEVELS),
      .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE)
   ) u_step (
      .word             (req_word_ff),
      .hdr_pending      (hdr_pending_ff),
      .cur_level        (current_level_ff),
      .level_index      (level_index_ff),
      .hdr_pending_in   (hdr_pending_in),
      .current_level_in (current_level_in),
      .level_index_in   (level_index_in),
      .has_result       (step_has_result),
      .rsp              (step_rsp)
   );

   // walk position
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pending_ff   <= 1'b1;
         current_level_ff <= LW'(LEVELS - 1);
         level_index_ff   <= '0;
      end else if (fire) begin
         hdr_pending_ff   <= hdr_pending_in;
         current_level_ff <= current_level_in;
         level_index_ff   <= level_index_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = step_has_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_has_result) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_leaf     = rsp_ff.is_leaf;
   assign rsp_leaf_level  = rsp_ff.leaf_level;
   assign rsp_phys_addr   = rsp_ff.phys_addr;
   assign rsp_virt_addr   = rsp_ff.virt_addr;
   assign rsp_can_write   = rsp_ff.can_write;
   assign rsp_can_execute = rsp_ff.can_execute;
   assign rsp_user_access = rsp_ff.user_access;
   assign rsp_walk_end    = rsp_ff.walk_end;

   // header beats never report anything
   a_hdr_silent : assert property (@(posedge clock) disable iff (reset)
      fire && hdr_pending_ff |-> !step_has_result)
      else $error("header beat produced a result");

   // finishing the root rearms the walker at the root header
   a_rearm : assert property (@(posedge clock) disable iff (reset)
      fire && step_has_result && step_rsp.walk_end
      |=> hdr_pending_ff && (current_level_ff == LW'(LEVELS - 1)))
      else $error("walker not rearmed after walk end");

   // every result beat is a leaf or an end marker
   a_rsp_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.is_leaf || rsp_ff.walk_end)
      else $error("empty result beat");

   // a descend leaves the level below expecting a header
   a_descend : assert property (@(posedge clock) disable iff (reset)
      fire && !hdr_pending_ff && hdr_pending_in && !step_has_result
      |=> hdr_pending_ff && (current_level_ff != LW'(LEVELS - 1)))
      else $error("descend did not move down to a header");

endmodule
`default_nettype wire

// ----- verif/tb_page_table_dump_walker.sv -----
// ----------------------------------------------------------------------------
// tb_page_table_dump_walker - self-checking bench for the dump walker
// Feeds depth-first page table dumps one word per beat. The dumps are built
// page by page: root-only walks, and a deep walk that dives down to the last
// level. A scoreboard class tracks the walk position of every
// accepted word, predicts the leaf and walk-end results, and compares each
// result beat field by field. Both sides idle in random bursts. The result
// side also holds off once for a long stretch so that the walker backs up.
// ----------------------------------------------------------------------------
module tb_page_table_dump_walker;
   import ptdw_pkg::*;

   localparam int N_LEVELS     = 4;
   localparam int N_ENTRIES    = 512;
   localparam int IDX_W        = $clog2(N_ENTRIES);
   localparam int STIM_WORDS   = 1300;
   localparam int QUIET_WORDS  = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // walk position tracker and store of pending leaf / walk-end results
   class leaf_scoreboard;
      int     walk_level;
      int     entry_idx [N_LEVELS];
      bit     header_due;
      rsp_type leaf_q [$];
      int     errors;
      int     n_leaves;
      int     n_ends;

      function new();
         rearm();
         errors = 0;
         n_leaves = 0;
         n_ends = 0;
      endfunction

      function void rearm();
         foreach (entry_idx[l]) entry_idx[l] = 0;
         walk_level = N_LEVELS - 1;
         header_due = 1'b1;
      endfunction

      function logic [VA_W-1:0] leaf_va(int lvl);
         logic [63:0] va;
         va = '0;
         for (int l = N_LEVELS - 1; l >= lvl; l--)
            va = (va << IDX_W) | 64'(entry_idx[l]);
         va = va << (lvl * IDX_W + PAGE_SHIFT);
         return va[VA_W-1:0];
      endfunction

      function void take_word(logic [63:0] w);
         rsp_type r;
         int      lvl;
         bit      leaf;
         bit      done;
         lvl = walk_level;
         if (header_due) begin
            header_due = 1'b0;
            entry_idx[lvl] = 0;
            return;
         end
         r = '0;
         leaf = 1'b0;
         done = 1'b0;
         if (lvl > 0) begin
            if (w[PRESENT_BIT]) begin
               if (!w[HUGE_BIT]) begin
                  walk_level = lvl - 1;
                  header_due = 1'b1;
                  return;
               end
               leaf = 1'b1;
            end
         end else begin
            // last level takes any nonzero entry, present or not
            leaf = (w != '0);
         end
         if (leaf) begin
            r.is_leaf     = 1'b1;
            r.leaf_level  = 2'(lvl);
            r.phys_addr   = {w[62:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            r.virt_addr   = leaf_va(lvl);
            r.can_write   = w[WRITE_BIT];
            r.can_execute = !w[NX_BIT];
            r.user_access = w[USER_BIT];
         end
         entry_idx[lvl]++;
         while (entry_idx[lvl] >= N_ENTRIES) begin
            if (lvl == N_LEVELS - 1) begin
               done = 1'b1;
               rearm();
               break;
            end
            lvl++;
            entry_idx[lvl]++;
         end
         if (!done) walk_level = lvl;
         r.walk_end = done;
         if (leaf || done) leaf_q.push_back(r);
      endfunction

      function void cmp(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_beat(rsp_type got);
         rsp_type want;
         if (leaf_q.size() == 0) begin
            $error("result beat with no result pending");
            errors++;
            return;
         end
         want = leaf_q.pop_front();
         if (want.is_leaf) n_leaves++;
         if (want.walk_end) n_ends++;
         cmp("is_leaf", want.is_leaf, got.is_leaf);
         cmp("leaf_level", want.leaf_level, got.leaf_level);
         cmp("phys_addr", want.phys_addr, got.phys_addr);
         cmp("virt_addr", want.virt_addr, got.virt_addr);
         cmp("can_write", want.can_write, got.can_write);
         cmp("can_execute", want.can_execute, got.can_execute);
         cmp("user_access", want.user_access, got.user_access);
         cmp("walk_end", want.walk_end, got.walk_end);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_leaf;
   logic [1:0]  rsp_leaf_level;
   logic [62:0] rsp_phys_addr;
   logic [47:0] rsp_virt_addr;
   logic        rsp_can_write;
   logic        rsp_can_execute;
   logic        rsp_user_access;
   logic        rsp_walk_end;

   leaf_scoreboard sb;
   int          words_sent = 0;
   int unsigned cycles = 0;
   bit          quiet = 1'b0;
   bit          hold_go = 1'b0;
   bit          hold_done = 1'b0;
   int          walk_no = 0;
   bit          end_on_leaf = 1'b0;
   int          dive_at [N_LEVELS];

   page_table_dump_walker #(
      .LEVELS            (N_LEVELS),
      .ENTRIES_PER_TABLE (N_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_leaf     (rsp_is_leaf),
      .rsp_leaf_level  (rsp_leaf_level),
      .rsp_phys_addr   (rsp_phys_addr),
      .rsp_virt_addr   (rsp_virt_addr),
      .rsp_can_write   (rsp_can_write),
      .rsp_can_execute (rsp_can_execute),
      .rsp_user_access (rsp_user_access),
      .rsp_walk_end    (rsp_walk_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycles, sb.leaf_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) sb.take_word(req_word);
         if (rsp_valid && !rsp_stall) begin
            seen.is_leaf     = rsp_is_leaf;
            seen.leaf_level  = rsp_leaf_level;
            seen.phys_addr   = rsp_phys_addr;
            seen.virt_addr   = rsp_virt_addr;
            seen.can_write   = rsp_can_write;
            seen.can_execute = rsp_can_execute;
            seen.user_access = rsp_user_access;
            seen.walk_end    = rsp_walk_end;
            sb.check_beat(seen);
         end
      end
   end

   // result side: random stall bursts, one long hold once the last level starts
   initial begin : result_sink
      while (reset) @(negedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_word(input logic [63:0] w);
      quiet = (words_sent >= STIM_WORDS - QUIET_WORDS);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   function automatic logic [63:0] table_ptr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      w[PRESENT_BIT] = 1'b1;
      w[HUGE_BIT]    = 1'b0;
      return w;
   endfunction

   function automatic logic [63:0] pick_entry(int lvl, int i);
      logic [63:0] w;
      w = {$urandom, $urandom};
      if (lvl == N_LEVELS - 1 && i == N_ENTRIES - 1) begin
         // last root entry decides whether the walk ends on a leaf
         w[PRESENT_BIT] = end_on_leaf;
         w[HUGE_BIT]    = 1'b1;
         return w;
      end
      if (i < 8 && lvl == N_LEVELS - 1 && walk_no == 0) begin
         case (i)
            0: return 64'h0;
            1: return {64{1'b1}};
            2: return 64'h0000_0000_0000_0081;
            3: return 64'hFFFF_FFFF_FFFF_FFFE;
            4: return 64'h0000_0000_0000_0080;
            5: return 64'h7FFF_FFFF_FFFF_F087;
            6: return 64'h8000_0000_0000_0083;
            default: return 64'h0000_0000_0000_1085;
         endcase
      end
      if (i < 8 && lvl == 0) begin
         case (i)
            0: return 64'h0000_0000_0000_0002;
            1: return 64'h0;
            2: return {64{1'b1}};
            3: return 64'h8000_0000_0000_0000;
            4: return 64'h0000_0000_0000_0001;
            5: return 64'h7FFF_FFFF_FFFF_F000;
            6: return 64'h0000_0000_0000_0080;
            default: return 64'h0000_0000_0000_0004;
         endcase
      end
      if (lvl == 0) begin
         if ($urandom_range(0, 3) == 0) w = '0;
         else if ($urandom_range(0, 3) == 0) w = 64'h1 << $urandom_range(0, 63);
      end else begin
         case ($urandom_range(0, 2))
            0: w[PRESENT_BIT] = 1'b0;
            1: begin
               w[PRESENT_BIT] = 1'b1;
               w[HUGE_BIT]    = 1'b1;
            end
            default: w = '0;
         endcase
      end
      return w;
   endfunction

   // one page in depth-first order: header, then its entries, diving where planned
   task automatic send_page(input int lvl);
      logic [63:0] hdr;
      hdr = (lvl == N_LEVELS - 1 && walk_no == 0) ? {64{1'b1}} : {$urandom, $urandom};
      if (lvl == 0) hold_go = 1'b1;
      send_word(hdr);
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (words_sent >= STIM_WORDS) return;
         if (lvl > 0 && i == dive_at[lvl]) begin
            send_word(table_ptr());
            send_page(lvl - 1);
         end else begin
            send_word(pick_entry(lvl, i));
         end
      end
   endtask

   initial begin
      sb = new();
      foreach (dive_at[l]) dive_at[l] = -1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // root-only walk ending on a huge leaf
      walk_no = 0;
      end_on_leaf = 1'b1;
      send_page(N_LEVELS - 1);

      // root-only walk ending on an absent entry
      walk_no = 1;
      end_on_leaf = 1'b0;
      send_page(N_LEVELS - 1);

      // deep walk: early dives at every level down to the last-level page
      walk_no = 2;
      dive_at[N_LEVELS - 1] = $urandom_range(0, 7);
      dive_at[N_LEVELS - 2] = $urandom_range(0, 7);
      dive_at[1] = $urandom_range(0, 7);
      send_page(N_LEVELS - 1);

      req_valid <= 1'b0;
      while (sb.leaf_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d dump words over %0d cycles across all four levels, with a %0d-cycle",
               words_sent, cycles, HOLD_CYCLES);
      $display("output hold; %0d leaf results and %0d walk ends checked",
               sb.n_leaves, sb.n_ends);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
